>>> src/tsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg: shared types, constants and helpers of the traction slip controller
// Field widths, register indexes, sequencer states and saturation helpers.
// ----------------------------------------------------------------------------
package tsp_pkg;

   typedef logic [15:0]        speed_type;
   typedef logic [23:0]        elapsed_type;
   typedef logic [23:0]        gain_type;
   typedef logic [15:0]        slip_type;
   typedef logic [16:0]        scale_type;
   typedef logic [30:0]        serr_type;
   typedef logic signed [31:0] q16_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_PROP_GAIN       = 3'd0;
   localparam csr_index_type CSR_DERIV_GAIN      = 3'd1;
   localparam csr_index_type CSR_TARGET_SLIP     = 3'd2;
   localparam csr_index_type CSR_MIN_SCALE       = 3'd3;
   localparam csr_index_type CSR_MAX_SCALE       = 3'd4;
   localparam csr_index_type CSR_MIN_FRONT_SPEED = 3'd5;

   localparam gain_type  RST_PROP_GAIN       = 24'd0;
   localparam gain_type  RST_DERIV_GAIN      = 24'd0;
   localparam slip_type  RST_TARGET_SLIP     = 16'd5898;
   localparam scale_type RST_MIN_SCALE       = 17'd6554;
   localparam scale_type RST_MAX_SCALE       = 17'd65536;
   localparam speed_type RST_MIN_FRONT_SPEED = 16'd100;

   localparam scale_type SCALE_ONE = 17'h1_0000;
   localparam logic signed [24:0] USEC_PER_SEC = 25'sd1000000;

   localparam q16_type Q16_MAX = 32'sh7FFF_FFFF;
   localparam q16_type Q16_MIN = 32'sh8000_0000;

   // restoring divider: one quotient bit per step
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV_SLIP,
      ST_ERROR,
      ST_MUL_DT,
      ST_DIV_LOAD,
      ST_DIV_DT,
      ST_DERIV,
      ST_MUL_P,
      ST_MUL_D,
      ST_SUM,
      ST_CLAMP,
      ST_DONE
   } state_type;

   // signed, saturated value of a quotient magnitude; ovf means q >= 2^32
   function automatic q16_type sat_quot(input logic neg, input logic ovf,
                                        input logic [31:0] q);
      q16_type r;
      if (!neg) begin
         r = (ovf || q[31]) ? Q16_MAX : q16_type'(q);
      end else if (ovf || (q > 32'h8000_0000)) begin
         r = Q16_MIN;
      end else begin
         r = q16_type'(-q);
      end
      return r;
   endfunction

   function automatic q16_type sat33(input logic signed [32:0] v);
      q16_type r;
      if (v[32] != v[31]) begin
         r = v[32] ? Q16_MIN : Q16_MAX;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> src/tsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_if: handshake channels of the traction slip controller
// Wheel speed request, torque response and register write channels.
// ----------------------------------------------------------------------------
interface tsp_req_if;
   logic                     valid;
   logic                     ready;
   tsp_pkg::speed_type       speed_front_left;
   tsp_pkg::speed_type       speed_front_right;
   tsp_pkg::speed_type       speed_rear_left;
   tsp_pkg::speed_type       speed_rear_right;
   tsp_pkg::elapsed_type     elapsed_us;

   modport source (output valid, output speed_front_left, output speed_front_right,
                   output speed_rear_left, output speed_rear_right,
                   output elapsed_us, input ready);
   modport sink   (input valid, input speed_front_left, input speed_front_right,
                   input speed_rear_left, input speed_rear_right,
                   input elapsed_us, output ready);
endinterface

interface tsp_rsp_if;
   logic                valid;
   logic                ready;
   tsp_pkg::scale_type  torque_scale;
   tsp_pkg::serr_type   stored_error;
   logic                bypassed;

   modport source (output valid, output torque_scale, output stored_error,
                   output bypassed, input ready);
   modport sink   (input valid, input torque_scale, input stored_error,
                   input bypassed, output ready);
endinterface

interface tsp_csr_if;
   logic                    valid;
   logic                    ready;
   tsp_pkg::csr_index_type  index;
   tsp_pkg::csr_data_type   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/traction_slip_pd_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traction_slip_pd_controller: PD torque limiter on wheel slip ratio
// Iterative datapath: one restoring divider and one multiplier under a
// small sequencer compute slip, error, derivative and clamped torque scale.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : four wheel speeds and the microseconds since the last word.
//   rsp_if  : one word per request: torque scale (Q1.16), the error kept
//             for the next derivative, and a bypass flag.
//   csr_if  : register writes, always ready; write only while idle.
// Sequence from request accept to rsp_if.valid:
//   bypass (front speed too low) goes straight to the response; otherwise
//   the 32-step slip division runs, then, unless the derivative is skipped,
//   a 32-step derivative division; the block returns to idle after the
//   response is taken.
//   One item is in flight at a time: req_if.ready is high only when idle.
// Reset: registers return to their defaults, the stored error clears and
//   is marked stale, so the first derivative after reset is zero.
// Stall: the response holds until rsp_if.ready; no new request is taken.
// ----------------------------------------------------------------------------
module traction_slip_pd_controller (
   input logic        clock,
   input logic        reset,
   tsp_req_if.sink    req_if,
   tsp_rsp_if.source  rsp_if,
   tsp_csr_if.sink    csr_if
);

   localparam logic [tsp_pkg::DIV_CNT_W-1:0] DIV_LAST =
      tsp_pkg::DIV_CNT_W'(tsp_pkg::DIV_STEPS - 1);

   tsp_pkg::state_type   state_ff, state_in;

   // configuration
   tsp_pkg::gain_type    prop_gain_ff;
   tsp_pkg::gain_type    deriv_gain_ff;
   tsp_pkg::slip_type    target_slip_ff;
   tsp_pkg::scale_type   min_scale_ff;
   tsp_pkg::scale_type   max_scale_ff;
   tsp_pkg::speed_type   min_front_speed_ff;

   // item
   logic [16:0]          fsum_ff, fsum_in;
   logic [16:0]          rsum_ff, rsum_in;
   tsp_pkg::elapsed_type elapsed_ff, elapsed_in;

   // divider
   logic [23:0]          div_rem_ff, div_rem_in;
   logic [31:0]          div_quo_ff, div_quo_in;
   logic [23:0]          div_den_ff, div_den_in;
   logic                 div_ovf_ff, div_ovf_in;
   logic                 div_neg_ff, div_neg_in;
   logic [tsp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // datapath
   tsp_pkg::q16_type     err_ff, err_in;
   tsp_pkg::q16_type     deriv_ff, deriv_in;
   logic signed [57:0]   mul_ff, mul_in;
   logic signed [58:0]   acc_ff, acc_in;

   // controller state
   tsp_pkg::q16_type     prev_err_ff, prev_err_in;
   logic                 stale_ff, stale_in;

   // response
   tsp_pkg::scale_type   torque_ff, torque_in;
   tsp_pkg::serr_type    serr_ff, serr_in;
   logic                 bypass_ff, bypass_in;

   // shared multiplier
   logic signed [32:0]   mul_a;
   logic signed [24:0]   mul_b;
   logic signed [57:0]   mul_prod;

   // comb helpers
   logic [24:0]          div_trial;
   logic                 div_fit;
   logic [24:0]          div_diff;
   logic signed [17:0]   sdiff;
   logic [16:0]          smag;
   tsp_pkg::q16_type     slip;
   logic signed [32:0]   err33;
   logic signed [32:0]   dd;
   logic [32:0]          dmag;
   logic [19:0]          dt_hi;
   logic signed [42:0]   floor43;
   logic signed [43:0]   res44;
   logic signed [43:0]   clamp44;

   assign req_if.ready        = (state_ff == tsp_pkg::ST_IDLE);
   assign rsp_if.valid        = (state_ff == tsp_pkg::ST_DONE);
   assign rsp_if.torque_scale = torque_ff;
   assign rsp_if.stored_error = serr_ff;
   assign rsp_if.bypassed     = bypass_ff;
   assign csr_if.ready        = 1'b1;

   always_comb begin
      case (state_ff)
         tsp_pkg::ST_MUL_DT: begin
            mul_a = $signed({1'b0, dmag[31:0]});
            mul_b = tsp_pkg::USEC_PER_SEC;
         end
         tsp_pkg::ST_MUL_D: begin
            mul_a = $signed({deriv_ff[31], deriv_ff});
            mul_b = $signed({1'b0, deriv_gain_ff});
         end
         default: begin
            mul_a = $signed({err_ff[31], err_ff});
            mul_b = $signed({1'b0, prop_gain_ff});
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   always_comb begin
      state_in    = state_ff;
      fsum_in     = fsum_ff;
      rsum_in     = rsum_ff;
      elapsed_in  = elapsed_ff;
      div_rem_in  = div_rem_ff;
      div_quo_in  = div_quo_ff;
      div_den_in  = div_den_ff;
      div_ovf_in  = div_ovf_ff;
      div_neg_in  = div_neg_ff;
      cnt_in      = cnt_ff;
      err_in      = err_ff;
      deriv_in    = deriv_ff;
      mul_in      = mul_ff;
      acc_in      = acc_ff;
      prev_err_in = prev_err_ff;
      stale_in    = stale_ff;
      torque_in   = torque_ff;
      serr_in     = serr_ff;
      bypass_in   = bypass_ff;

      // one restoring step
      div_trial = {div_rem_ff, div_quo_ff[31]};
      div_fit   = (div_trial >= {1'b0, div_den_ff});
      div_diff  = div_trial - {1'b0, div_den_ff};

      sdiff   = $signed({1'b0, rsum_ff}) - $signed({1'b0, fsum_ff});
      smag    = sdiff[17] ? 17'(-sdiff) : sdiff[16:0];
      slip    = tsp_pkg::sat_quot(div_neg_ff, div_ovf_ff, div_quo_ff);
      err33   = $signed({slip[31], slip}) - $signed({17'b0, target_slip_ff});
      dd      = $signed({err_ff[31], err_ff}) - $signed({1'b0, prev_err_ff});
      dmag    = dd[32] ? 33'(-dd) : dd;
      dt_hi   = mul_ff[51:32];
      floor43 = acc_ff[58:16];
      res44   = 44'sh100_00 - $signed({floor43[42], floor43});
      clamp44 = res44;
      if (clamp44 > $signed({27'b0, max_scale_ff})) begin
         clamp44 = $signed({27'b0, max_scale_ff});
      end
      if (clamp44 < $signed({27'b0, min_scale_ff})) begin
         clamp44 = $signed({27'b0, min_scale_ff});
      end

      case (state_ff)
         tsp_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               fsum_in    = {1'b0, req_if.speed_front_left} + {1'b0, req_if.speed_front_right};
               rsum_in    = {1'b0, req_if.speed_rear_left} + {1'b0, req_if.speed_rear_right};
               elapsed_in = req_if.elapsed_us;
               state_in   = tsp_pkg::ST_SETUP;
            end
         end
         tsp_pkg::ST_SETUP: begin
            if (fsum_ff <= {min_front_speed_ff, 1'b0}) begin
               prev_err_in = '0;
               stale_in    = 1'b1;
               torque_in   = tsp_pkg::SCALE_ONE;
               serr_in     = '0;
               bypass_in   = 1'b1;
               state_in    = tsp_pkg::ST_DONE;
            end else begin
               // dividend |rear - front| << 16, high bit above the 32 shifted in
               div_rem_in = {23'b0, smag[16]};
               div_quo_in = {smag[15:0], 16'b0};
               div_den_in = {7'b0, fsum_ff};
               div_ovf_in = ({23'b0, smag[16]} >= {7'b0, fsum_ff});
               div_neg_in = sdiff[17];
               cnt_in     = '0;
               state_in   = tsp_pkg::ST_DIV_SLIP;
            end
         end
         tsp_pkg::ST_DIV_SLIP, tsp_pkg::ST_DIV_DT: begin
            div_rem_in = div_fit ? div_diff[23:0] : div_trial[23:0];
            div_quo_in = {div_quo_ff[30:0], div_fit};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = (state_ff == tsp_pkg::ST_DIV_SLIP) ? tsp_pkg::ST_ERROR
                                                             : tsp_pkg::ST_DERIV;
            end
         end
         tsp_pkg::ST_ERROR: begin
            err_in = tsp_pkg::sat33(err33);
            if (stale_ff || (elapsed_ff == '0)) begin
               deriv_in = '0;
               state_in = tsp_pkg::ST_MUL_P;
            end else begin
               state_in = tsp_pkg::ST_MUL_DT;
            end
         end
         tsp_pkg::ST_MUL_DT: begin
            mul_in     = mul_prod;
            div_neg_in = dd[32];
            state_in   = tsp_pkg::ST_DIV_LOAD;
         end
         tsp_pkg::ST_DIV_LOAD: begin
            // quotient fits 32 bits only when the high part is below the divisor
            div_rem_in = {4'b0, dt_hi};
            div_quo_in = mul_ff[31:0];
            div_den_in = elapsed_ff;
            div_ovf_in = ({4'b0, dt_hi} >= elapsed_ff);
            cnt_in     = '0;
            state_in   = tsp_pkg::ST_DIV_DT;
         end
         tsp_pkg::ST_DERIV: begin
            deriv_in = slip;
            state_in = tsp_pkg::ST_MUL_P;
         end
         tsp_pkg::ST_MUL_P: begin
            mul_in   = mul_prod;
            state_in = tsp_pkg::ST_MUL_D;
         end
         tsp_pkg::ST_MUL_D: begin
            acc_in   = {mul_ff[57], mul_ff};
            mul_in   = mul_prod;
            state_in = tsp_pkg::ST_SUM;
         end
         tsp_pkg::ST_SUM: begin
            acc_in   = acc_ff + {mul_ff[57], mul_ff};
            state_in = tsp_pkg::ST_CLAMP;
         end
         tsp_pkg::ST_CLAMP: begin
            prev_err_in = err_ff[31] ? '0 : err_ff;
            stale_in    = 1'b0;
            torque_in   = clamp44[16:0];
            serr_in     = err_ff[31] ? '0 : err_ff[30:0];
            bypass_in   = 1'b0;
            state_in    = tsp_pkg::ST_DONE;
         end
         tsp_pkg::ST_DONE: begin
            if (rsp_if.ready) begin
               state_in = tsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= tsp_pkg::ST_IDLE;
         prev_err_ff        <= '0;
         stale_ff           <= 1'b1;
         prop_gain_ff       <= tsp_pkg::RST_PROP_GAIN;
         deriv_gain_ff      <= tsp_pkg::RST_DERIV_GAIN;
         target_slip_ff     <= tsp_pkg::RST_TARGET_SLIP;
         min_scale_ff       <= tsp_pkg::RST_MIN_SCALE;
         max_scale_ff       <= tsp_pkg::RST_MAX_SCALE;
         min_front_speed_ff <= tsp_pkg::RST_MIN_FRONT_SPEED;
      end else begin
         state_ff    <= state_in;
         prev_err_ff <= prev_err_in;
         stale_ff    <= stale_in;
         if (csr_if.valid) begin
            case (csr_if.index)
               tsp_pkg::CSR_PROP_GAIN:       prop_gain_ff       <= csr_if.data;
               tsp_pkg::CSR_DERIV_GAIN:      deriv_gain_ff      <= csr_if.data;
               tsp_pkg::CSR_TARGET_SLIP:     target_slip_ff     <= csr_if.data[15:0];
               tsp_pkg::CSR_MIN_SCALE:       min_scale_ff       <= csr_if.data[16:0];
               tsp_pkg::CSR_MAX_SCALE:       max_scale_ff       <= csr_if.data[16:0];
               tsp_pkg::CSR_MIN_FRONT_SPEED: min_front_speed_ff <= csr_if.data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      fsum_ff    <= fsum_in;
      rsum_ff    <= rsum_in;
      elapsed_ff <= elapsed_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_den_ff <= div_den_in;
      div_ovf_ff <= div_ovf_in;
      div_neg_ff <= div_neg_in;
      cnt_ff     <= cnt_in;
      err_ff     <= err_in;
      deriv_ff   <= deriv_in;
      mul_ff     <= mul_in;
      acc_ff     <= acc_in;
      torque_ff  <= torque_in;
      serr_ff    <= serr_in;
      bypass_ff  <= bypass_in;
   end

   // one word in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while a word is in flight");

   a_bypass_word: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.bypassed |->
         rsp_if.torque_scale == tsp_pkg::SCALE_ONE && rsp_if.stored_error == '0 && stale_ff)
      else $error("bypass word inconsistent with controller state");

   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.bypassed && (min_scale_ff <= max_scale_ff) |->
         rsp_if.torque_scale >= min_scale_ff && rsp_if.torque_scale <= max_scale_ff)
      else $error("torque scale outside clamp range");

   a_error_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.bypassed |->
         !stale_ff && !prev_err_ff[31] && rsp_if.stored_error == prev_err_ff[30:0])
      else $error("reported error differs from stored error");

endmodule

>>> test/traction_slip_pd_controller_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traction_slip_pd_controller_test: self-checking bench for the slip PD limiter
// Streams wheel speed words through the controller under a series of register
// settings, predicts every torque word in the bench and compares field by field.
// ----------------------------------------------------------------------------
module traction_slip_pd_controller_test;

   localparam int CLK_HALF      = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 80;     // settle time before the final queue check
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS   = 106;
   localparam int HOLD_CYCLES   = 600;
   localparam int MAX_PRINTS    = 40;
   localparam tsp_pkg::csr_index_type CSR_SPARE = 3'd7;   // decoded by nothing

   typedef struct {
      tsp_pkg::speed_type   front_left;
      tsp_pkg::speed_type   front_right;
      tsp_pkg::speed_type   rear_left;
      tsp_pkg::speed_type   rear_right;
      tsp_pkg::elapsed_type elapsed_us;
   } wheel_word_type;

   typedef struct {
      tsp_pkg::scale_type torque_scale;
      tsp_pkg::serr_type  stored_error;
      logic               bypassed;
   } torque_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tsp_req_if req_if();
   tsp_rsp_if rsp_if();
   tsp_csr_if csr_if();

   traction_slip_pd_controller dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #(CLK_HALF) clock = ~clock;

   // mirror of the controller registers and its error memory
   tsp_pkg::gain_type  kp          = tsp_pkg::RST_PROP_GAIN;
   tsp_pkg::gain_type  kd          = tsp_pkg::RST_DERIV_GAIN;
   tsp_pkg::slip_type  slip_target = tsp_pkg::RST_TARGET_SLIP;
   tsp_pkg::scale_type scale_floor = tsp_pkg::RST_MIN_SCALE;
   tsp_pkg::scale_type scale_ceil  = tsp_pkg::RST_MAX_SCALE;
   tsp_pkg::speed_type front_floor = tsp_pkg::RST_MIN_FRONT_SPEED;
   tsp_pkg::q16_type   held_error  = '0;
   logic               held_stale  = 1'b1;

   wheel_word_type  pending_words[$];
   torque_word_type expected_torque[$];
   wheel_word_type  offered;

   int burst_left     = 0;
   int gap_left       = 0;
   int gap_max        = 0;
   int stall_pct      = 0;
   int ready_run      = 0;
   logic ready_level  = 1'b1;
   int hold_left      = 0;
   int words_queued   = 0;
   int words_sent     = 0;
   int bypass_count   = 0;
   int results_seen   = 0;
   int settings_count = 0;
   int mismatches     = 0;
   int cycle_count    = 0;

   function automatic longint clip32(longint v);
      if (v > longint'(tsp_pkg::Q16_MAX)) return longint'(tsp_pkg::Q16_MAX);
      if (v < longint'(tsp_pkg::Q16_MIN)) return longint'(tsp_pkg::Q16_MIN);
      return v;
   endfunction

   function automatic torque_word_type predict_torque(wheel_word_type w);
      torque_word_type r;
      longint fsum, rsum, slip, err, deriv, acc, scale;
      fsum = longint'(w.front_left) + longint'(w.front_right);
      rsum = longint'(w.rear_left) + longint'(w.rear_right);
      if (fsum <= 2 * longint'(front_floor)) begin
         held_error = '0;
         held_stale = 1'b1;
         bypass_count++;
         r.torque_scale = tsp_pkg::SCALE_ONE;
         r.stored_error = '0;
         r.bypassed     = 1'b1;
         return r;
      end
      slip = clip32((rsum - fsum) * longint'(tsp_pkg::SCALE_ONE) / fsum);
      err  = clip32(slip - longint'(slip_target));
      deriv = 0;
      if (!held_stale && w.elapsed_us != 0)
         deriv = clip32((err - longint'(held_error)) * longint'(tsp_pkg::USEC_PER_SEC)
                        / longint'(w.elapsed_us));
      held_error = (err > 0) ? tsp_pkg::q16_type'(err) : '0;
      held_stale = 1'b0;
      acc   = longint'(kp) * err + longint'(kd) * deriv;
      scale = longint'(tsp_pkg::SCALE_ONE) - (acc >>> 16);   // floor to Q16.16
      if (scale > longint'(scale_ceil)) scale = longint'(scale_ceil);
      if (scale < longint'(scale_floor)) scale = longint'(scale_floor);
      r.torque_scale = tsp_pkg::scale_type'(scale);
      r.stored_error = tsp_pkg::serr_type'(held_error);
      r.bypassed     = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("mismatch in %s on result %0d: got 0x%0h, expected 0x%0h",
                  field, results_seen, got, want);
   endtask

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            expected_torque.push_back(predict_torque(offered));
            words_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               offered = pending_words.pop_front();
               req_if.speed_front_left  <= offered.front_left;
               req_if.speed_front_right <= offered.front_right;
               req_if.speed_rear_left   <= offered.rear_left;
               req_if.speed_rear_right  <= offered.rear_right;
               req_if.elapsed_us        <= offered.elapsed_us;
               req_if.valid             <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  if (gap_max > 0 && $urandom_range(3) != 0)
                     gap_left = $urandom_range(1, gap_max);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each torque word and stalls in runs of random length
   always @(posedge clock) begin
      torque_word_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_torque.size() == 0) begin
               report_mismatch("unexpected word", rsp_if.torque_scale, '0);
            end else begin
               want = expected_torque.pop_front();
               if (rsp_if.torque_scale !== want.torque_scale)
                  report_mismatch("torque_scale", rsp_if.torque_scale, want.torque_scale);
               if (rsp_if.stored_error !== want.stored_error)
                  report_mismatch("stored_error", rsp_if.stored_error, want.stored_error);
               if (rsp_if.bypassed !== want.bypassed)
                  report_mismatch("bypassed", rsp_if.bypassed, want.bypassed);
            end
         end
         if (ready_run == 0) begin
            ready_level = ($urandom_range(99) >= stall_pct);
            ready_run   = $urandom_range(1, 12);
         end
         ready_run--;
         rsp_if.ready <= ready_level && (hold_left == 0);
      end
   end

   // long receiver hold-off, so the block fills and backs up its input
   always @(posedge clock) begin
      if (hold_left > 0) hold_left--;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, expected_torque.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic write_reg(tsp_pkg::csr_index_type idx, tsp_pkg::csr_data_type value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         tsp_pkg::CSR_PROP_GAIN:       kp          = value;
         tsp_pkg::CSR_DERIV_GAIN:      kd          = value;
         tsp_pkg::CSR_TARGET_SLIP:     slip_target = value[15:0];
         tsp_pkg::CSR_MIN_SCALE:       scale_floor = value[16:0];
         tsp_pkg::CSR_MAX_SCALE:       scale_ceil  = value[16:0];
         tsp_pkg::CSR_MIN_FRONT_SPEED: front_floor = value[15:0];
         default: ;
      endcase
   endtask

   task automatic write_all(tsp_pkg::csr_data_type p, tsp_pkg::csr_data_type d,
                            tsp_pkg::csr_data_type t, tsp_pkg::csr_data_type lo,
                            tsp_pkg::csr_data_type hi, tsp_pkg::csr_data_type f);
      write_reg(tsp_pkg::CSR_PROP_GAIN, p);
      write_reg(tsp_pkg::CSR_DERIV_GAIN, d);
      write_reg(tsp_pkg::CSR_TARGET_SLIP, t);
      write_reg(tsp_pkg::CSR_MIN_SCALE, lo);
      write_reg(tsp_pkg::CSR_MAX_SCALE, hi);
      write_reg(tsp_pkg::CSR_MIN_FRONT_SPEED, f);
      settings_count++;
   endtask

   task automatic push_word(int fl, int fr, int rl, int rr, int el);
      wheel_word_type w;
      w.front_left  = tsp_pkg::speed_type'(fl);
      w.front_right = tsp_pkg::speed_type'(fr);
      w.rear_left   = tsp_pkg::speed_type'(rl);
      w.rear_right  = tsp_pkg::speed_type'(rr);
      w.elapsed_us  = tsp_pkg::elapsed_type'(el);
      pending_words.push_back(w);
      words_queued++;
   endtask

   // block is idle once every queued word has come back
   task automatic wait_idle();
      while (results_seen < words_queued)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic int to_speed(int v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
   endfunction

   function automatic int random_elapsed();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return 0;
      if (pick == 1) return $urandom_range(1, 10);
      if (pick == 2) return $urandom_range(0, 24'hFF_FFFF);
      return $urandom_range(200, 5000);
   endfunction

   task automatic push_random_word();
      int kind, lo, hi, base, s, rear, fsum, d;
      kind = $urandom_range(99);
      lo = int'(front_floor) + 1;
      if (lo > 65535) lo = 65535;
      if (kind < 12) begin
         push_word($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 24'hFF_FFFF));
      end else if (kind < 24) begin
         // front sum right around the bypass threshold
         d = $urandom_range(6);
         fsum = 2 * int'(front_floor) + d - 3;
         if (fsum < 0) fsum = 0;
         if (fsum > 131070) fsum = 131070;
         rear = $urandom_range(0, 65535);
         push_word(fsum / 2, fsum - fsum / 2, rear, to_speed(rear + 50), random_elapsed());
      end else begin
         // plausible driving: similar wheels, moderate slip either way
         hi = (lo < 12000) ? 12000 : 65535;
         base = $urandom_range(lo, hi);
         s = $urandom_range(80);
         s = s - 20;
         rear = base + base * s / 100;
         d = $urandom_range(40);
         push_word(to_speed(base + d - 20), base, to_speed(rear), to_speed(rear + d - 20),
                   random_elapsed());
      end
   endtask

   function automatic tsp_pkg::csr_data_type pick_value(int zero_w, int max_w,
                                                        tsp_pkg::csr_data_type top,
                                                        int lo, int hi);
      int pick;
      pick = $urandom_range(19);
      if (pick < zero_w) return '0;
      if (pick < zero_w + max_w) return top;
      if (pick < zero_w + max_w + 2) return tsp_pkg::csr_data_type'($urandom);
      return tsp_pkg::csr_data_type'($urandom_range(lo, hi));
   endfunction

   initial begin
      req_if.valid             = 1'b0;
      req_if.speed_front_left  = '0;
      req_if.speed_front_right = '0;
      req_if.speed_rear_left   = '0;
      req_if.speed_rear_right  = '0;
      req_if.elapsed_us        = '0;
      rsp_if.ready             = 1'b0;
      csr_if.valid             = 1'b0;
      csr_if.index             = tsp_pkg::CSR_PROP_GAIN;
      csr_if.data              = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: gains zero, so only bypass and stored error move
      gap_max = 4;
      stall_pct = 30;
      push_word(0, 0, 0, 0, 0);
      push_word(100, 100, 500, 500, 1000);        // front sum exactly at threshold
      push_word(100, 101, 120, 120, 1000);        // just above it
      push_word(65535, 65535, 65535, 65535, 24'hFF_FFFF);
      push_word(65535, 65535, 0, 0, 1);
      wait_idle();

      // unit proportional gain, no speed floor
      write_all(24'd65536, 24'd64, 24'd5898, 24'd6554, 24'd65536, 24'd0);
      push_word(1, 0, 65535, 65535, 1);           // slip and derivative saturate
      push_word(0, 0, 0, 0, 1000);                // zero front sum still bypasses
      push_word(2000, 2000, 2200, 2200, 1000);    // stale: no derivative
      push_word(2000, 2000, 2400, 2400, 0);       // zero elapsed time
      push_word(2000, 2000, 2600, 2600, 1000);
      push_word(3000, 3000, 2000, 2000, 500);     // negative error
      push_word(3000, 3000, 3000, 3000, 500);
      wait_idle();

      // extremes, lower clamp above upper clamp
      write_all(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'd1);
      write_reg(CSR_SPARE, tsp_pkg::csr_data_type'($urandom));
      push_word(4000, 4000, 8000, 8000, 1);
      push_word(10, 10, 10, 10, 24'hFF_FFFF);
      push_word(5, 5, 0, 0, 2);
      wait_idle();

      write_reg(tsp_pkg::CSR_MIN_FRONT_SPEED, 24'h00_FFFF);  // everything bypasses
      push_word(65535, 65535, 65535, 65535, 100);
      push_word(65535, 65534, 0, 0, 100);
      wait_idle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_all(pick_value(2, 1, 24'hFF_FFFF, 4096, 262144),
                   pick_value(2, 1, 24'hFF_FFFF, 0, 2048),
                   pick_value(2, 1, 24'h00_FFFF, 0, 20000),
                   pick_value(2, 1, 24'd65536, 0, 40000),
                   pick_value(1, 2, 24'd65536, 30000, 65536),
                   pick_value(2, 1, 24'h00_FFFF, 0, 600));
         case (ph % 4)
            0: begin gap_max = 0;  stall_pct = 0;  end
            1: begin gap_max = 30; stall_pct = 30; end
            2: begin gap_max = 4;  stall_pct = 70; end
            default: begin gap_max = 0; stall_pct = 10; end
         endcase
         if (ph == 3) hold_left = HOLD_CYCLES;
         for (int n = 0; n < PHASE_WORDS; n++) push_random_word();
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_torque.size() != 0)
         report_mismatch("missing results", '0, expected_torque.size());
      $display("covered %0d wheel words (%0d bypassed) under %0d register settings",
               words_sent, bypass_count, settings_count + 1);
      $display("checked %0d torque words, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
